### hw/rtl/cfdl_pkg.sv
// Shared types, constants and codes of the cohesive friction damage law core.
`timescale 1ns / 1ps

package cfdl_pkg;

    localparam int NODE_COUNT_DEFAULT = 1024;

    localparam int NODE_IN_W  = 10;
    localparam int DISP_W     = 32;
    localparam int STRESS_W   = 31;
    localparam int FRIC_W     = 20;
    localparam int REL_OPEN_W = 21;
    localparam int REL_SLIP_W = 20;
    localparam int LAW_W      = 2;
    localparam int FACTOR_W   = 17;
    localparam int MEM_W      = REL_OPEN_W + REL_SLIP_W;

    localparam int DVD_W  = 48;
    localparam int DVS_W  = 31;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 128;
    localparam int ADDR_W     = 5;

    localparam logic [16:0] Q_ONE = 17'd65536;
    localparam logic [REL_SLIP_W-1:0] REL_SLIP_MAX = 20'hFFFFF;

    localparam logic OP_EVALUATE = 1'b0;
    localparam logic OP_UPDATE   = 1'b1;

    localparam logic [LAW_W-1:0] COH_BOX    = 2'd0;
    localparam logic [LAW_W-1:0] COH_LINEAR = 2'd1;
    localparam logic [LAW_W-1:0] FRIC_CONST = 2'd0;
    localparam logic [LAW_W-1:0] FRIC_SLIP  = 2'd1;

    localparam logic [2:0] REG_CRIT_OPEN  = 3'd0;
    localparam logic [2:0] REG_CRIT_SLIP  = 3'd1;
    localparam logic [2:0] REG_PEAK_TEN   = 3'd2;
    localparam logic [2:0] REG_PEAK_SHEAR = 3'd3;
    localparam logic [2:0] REG_PEAK_FRIC  = 3'd4;
    localparam logic [2:0] REG_RESID_FRIC = 3'd5;
    localparam logic [2:0] REG_COH_LAW    = 3'd6;
    localparam logic [2:0] REG_FRIC_LAW   = 3'd7;

    localparam logic [STRESS_W-1:0] CRIT_RESET = 31'd16777216;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ1,
        ST_SQ2,
        ST_ROOT_GO,
        ST_REDUCE,
        ST_ROOT_W,
        ST_DSLIP_GO,
        ST_DSLIP_W,
        ST_DOPEN_GO,
        ST_DOPEN_W,
        ST_COH,
        ST_RMUL,
        ST_DR_GO,
        ST_DR_W,
        ST_MUL_OPEN,
        ST_MUL_SLIP,
        ST_FRIC_MUL,
        ST_FRIC_SUM,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

### hw/rtl/cfdl_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module cfdl_div
    import cfdl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        rem_sh    = {rem_reg, quo_reg[DVD_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W - 1);
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            // The dividend shifts out at the top while quotient bits enter below.
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(rem_sh - {1'b0, dvs_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hw/rtl/cfdl_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps

module cfdl_isqrt
    import cfdl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_sh    = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial     = (REM_W + 2)'({root_reg, 2'b01});
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ROOT_W - 1);
            rem_next  = '0;
            rad_next  = req.radicand;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

### hw/rtl/cfdl_store.sv
// Per-node damage memory with a clearing pass after reset.
`timescale 1ns / 1ps

module cfdl_store
    import cfdl_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEFAULT,
    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [MEM_W-1:0]      rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [MEM_W-1:0]      wr_data,
    output logic                  ready
);

    logic [MEM_W-1:0] mem [NODE_COUNT];
    logic [MEM_W-1:0] rd_data_reg;
    logic             clearing_reg, clearing_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             w_en;
    logic [AW-1:0]    w_addr;
    logic [MEM_W-1:0] w_data;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(NODE_COUNT - 1))
            begin
                clearing_next = 1'b0;
            end
        end
        w_en   = clearing_reg || wr_en;
        w_addr = clearing_reg ? clr_addr_reg : wr_addr;
        w_data = clearing_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_en)
        begin
            mem[w_addr] <= w_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clearing_reg;

endmodule

### hw/rtl/cohesive_friction_damage_law_core.sv
// Top level of the cohesive friction damage law core: sequencer, datapath and registers.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tdata (node, displacements), s_tuser (operation)
// m_axis    out        m_tvalid/m_tready  m_tdata (cohesions, friction, relative values)
// apb       in/out     psel/penable       paddr, pwdata, prdata, pready tied high
//
// One item takes two squaring steps, the square root, then two divisions on the shared
// restoring divider, and a third division when the cohesion factor of an evaluate item
// is scaled by the stored opening maximum; the divider sets the rate. After reset the
// node memory is cleared one entry per cycle, and no item is accepted meanwhile. A new
// item is taken while a finished result waits in the
// output register; the sequencer stalls only if a second result would overwrite it.

module cohesive_friction_damage_law_core
    import cfdl_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [9:0] node, [41:10] shear_first, [73:42] shear_second, [105:74] opening
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [30:0] opening_stress, [61:31] shear_stress, [81:62] friction_coefficient,
    // [102:82] relative_opening, [122:103] relative_slip
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int RED_W = NODE_IN_W + 17;

    // Configuration registers.
    logic [STRESS_W-1:0] crit_open_reg, crit_slip_reg, peak_ten_reg, peak_shear_reg;
    logic [FRIC_W-1:0]   peak_fric_reg, resid_fric_reg;
    logic [LAW_W-1:0]    coh_law_reg, fric_law_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_open_reg  <= CRIT_RESET;
            crit_slip_reg  <= CRIT_RESET;
            peak_ten_reg   <= '0;
            peak_shear_reg <= '0;
            peak_fric_reg  <= '0;
            resid_fric_reg <= '0;
            coh_law_reg    <= '0;
            fric_law_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_CRIT_OPEN:  crit_open_reg  <= pwdata[STRESS_W-1:0];
                REG_CRIT_SLIP:  crit_slip_reg  <= pwdata[STRESS_W-1:0];
                REG_PEAK_TEN:   peak_ten_reg   <= pwdata[STRESS_W-1:0];
                REG_PEAK_SHEAR: peak_shear_reg <= pwdata[STRESS_W-1:0];
                REG_PEAK_FRIC:  peak_fric_reg  <= pwdata[FRIC_W-1:0];
                REG_RESID_FRIC: resid_fric_reg <= pwdata[FRIC_W-1:0];
                REG_COH_LAW:    coh_law_reg    <= pwdata[LAW_W-1:0];
                REG_FRIC_LAW:   fric_law_reg   <= pwdata[LAW_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_CRIT_OPEN:  prdata = 32'(crit_open_reg);
            REG_CRIT_SLIP:  prdata = 32'(crit_slip_reg);
            REG_PEAK_TEN:   prdata = 32'(peak_ten_reg);
            REG_PEAK_SHEAR: prdata = 32'(peak_shear_reg);
            REG_PEAK_FRIC:  prdata = 32'(peak_fric_reg);
            REG_RESID_FRIC: prdata = 32'(resid_fric_reg);
            REG_COH_LAW:    prdata = 32'(coh_law_reg);
            REG_FRIC_LAW:   prdata = 32'(fric_law_reg);
            default:        prdata = '0;
        endcase
    end

    // Sequencer and item registers.
    state_t state_reg, state_next;

    logic                       op_reg;
    logic [NODE_IN_W-1:0]       node_reg;
    logic signed [DISP_W-1:0]   shear1_reg, shear2_reg, open_dd_reg;
    logic [RAD_W-1:0]           sq_reg;
    logic [3:0]                 red_cnt_reg;
    logic [ROOT_W-1:0]          root_reg;
    logic [REL_SLIP_W-1:0]      rs_reg;
    logic signed [REL_OPEN_W-1:0] ro_reg;
    logic [FACTOR_W-1:0]        r_reg;
    logic [36:0]                rr_prod_reg;
    logic [STRESS_W-1:0]        open_c_reg, slip_c_reg;
    logic signed [41:0]         fric_prod_reg;
    logic [FRIC_W-1:0]          fric_reg;

    logic                       out_valid_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    logic                 mem_ready, mem_rd_en, mem_wr_en;
    logic [AW-1:0]        mem_addr;
    logic [MEM_W-1:0]     mem_rd_data, mem_wr_data;

    logic signed [REL_OPEN_W-1:0] pr_open;
    logic [REL_SLIP_W-1:0]        pr_slip;
    logic                         out_free, finish_go;
    logic                         ro_pos, ro_lt_one, need_scale;
    logic [DVS_W-1:0]             crit_open_dvs, crit_slip_dvs;
    logic [DISP_W-1:0]            open_mag;
    logic [RED_W-1:0]             red_cmp;

    assign pr_open   = $signed(mem_rd_data[MEM_W-1:REL_SLIP_W]);
    assign pr_slip   = mem_rd_data[REL_SLIP_W-1:0];
    assign out_free  = !out_valid_reg || m_tready;
    assign finish_go = (state_reg == ST_FINISH) && out_free;
    assign ro_pos    = ro_reg > 0;
    assign ro_lt_one = ro_reg < $signed({4'd0, Q_ONE});
    assign need_scale = ro_pos && (ro_reg < pr_open);
    assign crit_open_dvs = (crit_open_reg == '0) ? DVS_W'(1) : crit_open_reg;
    assign crit_slip_dvs = (crit_slip_reg == '0) ? DVS_W'(1) : crit_slip_reg;
    assign open_mag  = open_dd_reg[DISP_W-1] ? DISP_W'(-open_dd_reg) : DISP_W'(open_dd_reg);
    assign red_cmp   = RED_W'(NODE_COUNT) << red_cnt_reg;
    assign mem_addr  = AW'(node_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid && s_tready) state_next = ST_SQ1;
            ST_SQ1:      state_next = ST_SQ2;
            ST_SQ2:      state_next = ST_ROOT_GO;
            ST_ROOT_GO:  state_next = ST_REDUCE;
            ST_REDUCE:   if (red_cnt_reg == 4'd0) state_next = ST_ROOT_W;
            ST_ROOT_W:   if (sqrt_rsp.done) state_next = ST_DSLIP_GO;
            ST_DSLIP_GO: state_next = ST_DSLIP_W;
            ST_DSLIP_W:  if (div_rsp.done) state_next = ST_DOPEN_GO;
            ST_DOPEN_GO: state_next = ST_DOPEN_W;
            ST_DOPEN_W:  if (div_rsp.done) state_next = ST_COH;
            ST_COH:
            begin
                if (op_reg == OP_UPDATE)
                begin
                    state_next = ST_FINISH;
                end
                else if (need_scale)
                begin
                    state_next = ST_RMUL;
                end
                else
                begin
                    state_next = ST_MUL_OPEN;
                end
            end
            ST_RMUL:     state_next = ST_DR_GO;
            ST_DR_GO:    state_next = ST_DR_W;
            ST_DR_W:     if (div_rsp.done) state_next = ST_MUL_OPEN;
            ST_MUL_OPEN: state_next = ST_MUL_SLIP;
            ST_MUL_SLIP: state_next = ST_FRIC_MUL;
            ST_FRIC_MUL: state_next = ST_FRIC_SUM;
            ST_FRIC_SUM: state_next = ST_FINISH;
            ST_FINISH:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_tready          = (state_reg == ST_IDLE) && mem_ready;
        sqrt_req.start    = (state_reg == ST_ROOT_GO);
        sqrt_req.radicand = sq_reg;
        mem_rd_en         = (state_reg == ST_ROOT_W);
        mem_wr_en         = finish_go && (op_reg == OP_UPDATE);
        div_req.start     = (state_reg == ST_DSLIP_GO) || (state_reg == ST_DOPEN_GO)
                            || (state_reg == ST_DR_GO);
        unique case (state_reg)
            ST_DSLIP_GO:
            begin
                div_req.dividend = {root_reg, 16'd0};
                div_req.divisor  = crit_slip_dvs;
            end
            ST_DOPEN_GO:
            begin
                div_req.dividend = {open_mag, 16'd0};
                div_req.divisor  = crit_open_dvs;
            end
            default:
            begin
                div_req.dividend = DVD_W'(rr_prod_reg);
                div_req.divisor  = DVS_W'(pr_open[REL_SLIP_W-1:0]);
            end
        endcase
    end

    // Update rule: slip keeps its maximum; an opening that exceeds the old maximum is stored,
    // else an opening of one or more stores one, and otherwise the old maximum stays.
    always_comb
    begin
        logic signed [REL_OPEN_W-1:0] new_open;
        logic [REL_SLIP_W-1:0]        new_slip;
        new_slip = (rs_reg > pr_slip) ? rs_reg : pr_slip;
        new_open = pr_open;
        if (!ro_lt_one)
        begin
            new_open = $signed({4'd0, Q_ONE});
        end
        if (ro_reg > pr_open)
        begin
            new_open = ro_reg;
        end
        mem_wr_data = {new_open, new_slip};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        logic [47:0]        wide_prod;
        logic signed [20:0] diff;
        logic signed [20:0] t_slip;
        logic [REL_SLIP_W-1:0] m_slip;
        logic signed [25:0] fq;
        logic signed [27:0] fsum;
        logic [REL_SLIP_W-1:0] rs_sat;
        wide_prod = '0;
        diff      = '0;
        t_slip    = '0;
        m_slip    = '0;
        fq        = '0;
        fsum      = '0;
        rs_sat    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    op_reg      <= s_tuser;
                    node_reg    <= s_tdata[9:0];
                    shear1_reg  <= $signed(s_tdata[41:10]);
                    shear2_reg  <= $signed(s_tdata[73:42]);
                    open_dd_reg <= $signed(s_tdata[105:74]);
                end
            end
            ST_SQ1:
            begin
                sq_reg <= RAD_W'(unsigned'(64'(shear1_reg * shear1_reg)));
            end
            ST_SQ2:
            begin
                sq_reg <= sq_reg + RAD_W'(unsigned'(64'(shear2_reg * shear2_reg)));
            end
            ST_ROOT_GO:
            begin
                red_cnt_reg <= 4'd9;
            end
            ST_REDUCE:
            begin
                // Node index modulo NODE_COUNT by shifted compare and subtract.
                if (RED_W'(node_reg) >= red_cmp)
                begin
                    node_reg <= node_reg - NODE_IN_W'(red_cmp);
                end
                red_cnt_reg <= red_cnt_reg - 1'b1;
            end
            ST_ROOT_W:
            begin
                if (sqrt_rsp.done)
                begin
                    root_reg <= sqrt_rsp.root;
                end
            end
            ST_DSLIP_W:
            begin
                if (div_rsp.done)
                begin
                    rs_sat = (div_rsp.quotient > DVD_W'(REL_SLIP_MAX)) ? REL_SLIP_MAX
                             : div_rsp.quotient[REL_SLIP_W-1:0];
                    rs_reg <= rs_sat;
                end
            end
            ST_DOPEN_W:
            begin
                if (div_rsp.done)
                begin
                    if (!open_dd_reg[DISP_W-1])
                    begin
                        ro_reg <= (div_rsp.quotient > DVD_W'(20'hFFFFF)) ? 21'sd1048575
                                  : $signed({1'b0, div_rsp.quotient[19:0]});
                    end
                    else
                    begin
                        ro_reg <= (div_rsp.quotient > DVD_W'(21'h100000)) ? -21'sd1048576
                                  : REL_OPEN_W'(-$signed({1'b0, div_rsp.quotient[20:0]}));
                    end
                end
            end
            ST_COH:
            begin
                if (ro_pos && ro_lt_one && coh_law_reg == COH_BOX)
                begin
                    r_reg <= Q_ONE;
                end
                else if (ro_pos && ro_lt_one && coh_law_reg == COH_LINEAR)
                begin
                    r_reg <= Q_ONE - FACTOR_W'(ro_reg[16:0]);
                end
                else
                begin
                    r_reg <= '0;
                end
            end
            ST_RMUL:
            begin
                rr_prod_reg <= 37'(r_reg) * 37'(ro_reg[19:0]);
            end
            ST_DR_W:
            begin
                if (div_rsp.done)
                begin
                    r_reg <= div_rsp.quotient[FACTOR_W-1:0];
                end
            end
            ST_MUL_OPEN:
            begin
                wide_prod  = 48'(peak_ten_reg) * 48'(r_reg);
                open_c_reg <= wide_prod[46:16];
            end
            ST_MUL_SLIP:
            begin
                wide_prod  = 48'(peak_shear_reg) * 48'(r_reg);
                slip_c_reg <= wide_prod[46:16];
            end
            ST_FRIC_MUL:
            begin
                m_slip = (rs_reg > pr_slip) ? rs_reg : pr_slip;
                t_slip = $signed({4'd0, Q_ONE}) - $signed({1'b0, m_slip});
                diff   = $signed({1'b0, peak_fric_reg}) - $signed({1'b0, resid_fric_reg});
                fric_prod_reg <= 42'(diff) * 42'(t_slip);
            end
            ST_FRIC_SUM:
            begin
                // Division by one in Q4.16 rounds toward zero for negative products.
                if (fric_prod_reg < 0)
                begin
                    fq = 26'((fric_prod_reg + 42'sd65535) >>> 16);
                end
                else
                begin
                    fq = 26'(fric_prod_reg >>> 16);
                end
                fsum = 28'($signed({1'b0, resid_fric_reg})) + 28'(fq);
                if (!ro_lt_one)
                begin
                    fric_reg <= '0;
                end
                else if (fric_law_reg == FRIC_CONST)
                begin
                    fric_reg <= peak_fric_reg;
                end
                else if (fric_law_reg == FRIC_SLIP && rs_reg < REL_SLIP_W'(Q_ONE))
                begin
                    if (fsum < 0)
                    begin
                        fric_reg <= '0;
                    end
                    else if (fsum > 28'sd1048575)
                    begin
                        fric_reg <= 20'hFFFFF;
                    end
                    else
                    begin
                        fric_reg <= fsum[FRIC_W-1:0];
                    end
                end
                else
                begin
                    fric_reg <= resid_fric_reg;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (op_reg == OP_UPDATE)
                    begin
                        out_data_reg <= {5'd0, rs_reg, ro_reg, 20'd0, 31'd0, 31'd0};
                    end
                    else
                    begin
                        out_data_reg <= {5'd0, rs_reg, ro_reg, fric_reg, slip_c_reg,
                                         open_c_reg};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    cfdl_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    cfdl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    cfdl_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_addr),
        .wr_data (mem_wr_data),
        .ready   (mem_ready)
    );

    // A divider result arrives only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DSLIP_W || state_reg == ST_DOPEN_W
                          || state_reg == ST_DR_W))
        else $error("divider result outside a wait state");

    // A new result appears only after the finishing step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised without finishing an item");

    // The memory is written only for update items and never during the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (op_reg == OP_UPDATE) && mem_ready)
        else $error("unexpected memory write");

    // The square root finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_rsp.done |-> state_reg == ST_ROOT_W)
        else $error("square root result outside its wait state");

endmodule
